// File: hw/rtl/sts_pkg.sv
// Shared definitions for the sorted table binary search block.
// Field widths, command codes and default table depth; no dependencies.
package sts_pkg;

    localparam int VALUE_W       = 32;
    localparam int INDEX_W       = 10;
    localparam int COUNT_W       = 11;
    localparam int TABLE_DEPTH_D = 1024;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

endpackage

// File: hw/rtl/sts_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// Standalone; used for the entry table of the search core.
module sts_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/sorted_table_binary_search_core.sv
// Top level of the sorted table binary search block; uses sts_pkg and sts_ram.
// A write transfer stores one table entry. A search transfer bisects the first
// entry_count entries (saturated to TABLE_DEPTH) with one table read per probe; every probe
// takes a read state (S_LOOP) and a compare state (S_CMP), because the table RAM read port is
// registered. Unless a probe hits, a search ends with the final checks of entries high and
// low (S_CHKH, S_CHKL); an empty table goes straight to the answer in S_DONE.
// One item is worked at a time; a finished result sits in the output register, so the next
// item is accepted while it waits. The table is not cleared at reset and must be written
// before it is searched.
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_D
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sts_pkg::COUNT_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [sts_pkg::INDEX_W-1:0] s_entry_index,
    input  logic signed [sts_pkg::VALUE_W-1:0] s_entry_value,
    input  logic signed [sts_pkg::VALUE_W-1:0] s_search_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [sts_pkg::INDEX_W-1:0] m_match_index
);
    import sts_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CW     = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOOP = 6'b000010,
        S_CMP  = 6'b000100,
        S_CHKH = 6'b001000,
        S_CHKL = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [ADDR_W-1:0]         low_reg, low_next;
    logic [ADDR_W-1:0]         high_reg, high_next;
    logic [ADDR_W-1:0]         where_reg, where_next;
    logic                      hit_reg, hit_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_found_reg, m_found_next;
    logic [INDEX_W-1:0]        m_index_reg, m_index_next;

    logic                      s_xfer;
    logic [CW-1:0]             idx_ext;
    logic [CW-1:0]             cnt_ext;
    logic [CW-1:0]             cnt_sat;
    logic [ADDR_W:0]           sum;
    logic [ADDR_W-1:0]         mid;
    logic [ADDR_W:0]           span;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_raddr;
    logic signed [VALUE_W-1:0] ram_rdata;
    logic                      out_free;
    logic [CW-1:0]             where_ext;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_xfer    = s_valid && s_ready;

    assign idx_ext = CW'(s_entry_index);
    assign cnt_ext = CW'(count_reg);
    assign cnt_sat = (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;
    assign sum     = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid     = sum[ADDR_W:1];
    assign span    = {1'b0, high_reg} - {1'b0, low_reg};

    assign ram_we    = s_xfer && (s_cmd == CMD_WRITE) && (idx_ext < CW'(TABLE_DEPTH));
    assign out_free  = !m_valid_reg || m_ready;
    assign where_ext = CW'(where_reg);

    always_comb begin
        case (state_reg)
            S_LOOP:  ram_raddr = (span > (ADDR_W + 1)'(1)) ? mid : high_reg;
            S_CHKH:  ram_raddr = low_reg;
            default: ram_raddr = mid;
        endcase
    end

    sts_ram #(
        .DATA_W (VALUE_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_ext[ADDR_W-1:0]),
        .wdata (s_entry_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        where_next   = where_reg;
        hit_next     = hit_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_found_next = m_found_reg;
        m_index_next = m_index_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer && (s_cmd == CMD_SEARCH)) begin
                    key_next   = s_search_key;
                    low_next   = '0;
                    high_next  = ADDR_W'(cnt_sat - CW'(1));
                    hit_next   = 1'b0;
                    where_next = '0;
                    state_next = (cnt_sat == '0) ? S_DONE : S_LOOP;
                end
            end
            S_LOOP: begin
                state_next = (span > (ADDR_W + 1)'(1)) ? S_CMP : S_CHKH;
            end
            S_CMP: begin
                if (ram_rdata == key_reg) begin
                    hit_next   = 1'b1;
                    where_next = mid;
                    state_next = S_DONE;
                end else if (ram_rdata > key_reg) begin
                    high_next  = mid;
                    state_next = S_LOOP;
                end else begin
                    low_next   = mid;
                    state_next = S_LOOP;
                end
            end
            S_CHKH: begin
                if (ram_rdata == key_reg) begin
                    hit_next   = 1'b1;
                    where_next = high_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_CHKL;
                end
            end
            S_CHKL: begin
                if (ram_rdata == key_reg) begin
                    hit_next   = 1'b1;
                    where_next = low_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = hit_reg;
                    m_index_next = hit_reg ? where_ext[INDEX_W-1:0] : '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        low_reg     <= low_next;
        high_reg    <= high_next;
        where_reg   <= where_next;
        hit_reg     <= hit_next;
        key_reg     <= key_next;
        m_found_reg <= m_found_next;
        m_index_reg <= m_index_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_match_index = m_index_reg;

endmodule

// File: hw/rtl/sts_checker.sv
// Port-level checks for the sorted table binary search core, attached by bind.
// Depends on sts_pkg and sorted_table_binary_search_core.
module sts_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_cmd,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_found,
    input logic [sts_pkg::INDEX_W-1:0] m_match_index
);
    import sts_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_match_index))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_index == '0)
        else $error("miss with nonzero index");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_WRITE) && !m_valid |=> !m_valid)
        else $error("write transfer produced a result");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_SEARCH) |=> !s_ready)
        else $error("input accepted during a search");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind sorted_table_binary_search_core sts_checker u_sts_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for sorted_table_binary_search_core: table writes, searches, count setup.
// Predicts each search answer from a shadow copy of the table; depends on sts_pkg and the core RTL.
module tb;
    import sts_pkg::*;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam int  ITEM_TARGET   = 1000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  LONG_HOLD     = 300;
    localparam int  FULL_PHASE    = 3;
    localparam longint LIMIT_CYCLES = 3_000_000;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } search_answer_t;

    typedef enum {FILL_DENSE, FILL_SPARSE, FILL_SHUFFLED} fill_mode_t;

    class bisect_tracker;
        logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH_D];
        logic [COUNT_W-1:0]        entry_count;
        search_answer_t            pending_answers [$];
        int                        errors;

        function new();
            entry_count = '0;
            errors = 0;
        endfunction

        function search_answer_t bisect_lookup(logic signed [VALUE_W-1:0] key);
            search_answer_t answer;
            int span, lo, hi, mid;
            answer = '0;
            span = (entry_count > TABLE_DEPTH_D) ? TABLE_DEPTH_D : int'(entry_count);
            if (span == 0) return answer;
            lo = 0;
            hi = span - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (table_copy[mid] == key) begin
                    answer.found = 1'b1;
                    answer.index = INDEX_W'(mid);
                    return answer;
                end
                if (table_copy[mid] > key) hi = mid;
                else lo = mid;
            end
            if (table_copy[hi] == key) begin
                answer.found = 1'b1;
                answer.index = INDEX_W'(hi);
            end else if (table_copy[lo] == key) begin
                answer.found = 1'b1;
                answer.index = INDEX_W'(lo);
            end
            return answer;
        endfunction

        function void note_input(logic cmd, logic [INDEX_W-1:0] idx,
                                 logic signed [VALUE_W-1:0] val,
                                 logic signed [VALUE_W-1:0] key);
            if (cmd == CMD_WRITE) table_copy[idx] = val;
            else pending_answers.push_back(bisect_lookup(key));
        endfunction

        function void check_result(logic found, logic [INDEX_W-1:0] idx);
            search_answer_t want;
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found=%0b match_index=%0d", $time, found, idx);
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found) begin
                errors++;
                $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            end
            if (idx !== want.index) begin
                errors++;
                $display("%0t: match_index expected %0d actual %0d", $time, want.index, idx);
            end
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [COUNT_W-1:0]          cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_cmd = CMD_WRITE;
    logic [INDEX_W-1:0]          s_entry_index = '0;
    logic signed [VALUE_W-1:0]   s_entry_value = '0;
    logic signed [VALUE_W-1:0]   s_search_key = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_found;
    logic [INDEX_W-1:0]          m_match_index;

    bisect_tracker tracker = new();
    int tx_gap_max = 11;
    int rx_stall_max = 11;
    bit long_hold = 1'b0;
    int random_items = 0;

    sorted_table_binary_search_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_search_key  (s_search_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_found, m_match_index);
    end

    initial begin : result_drain
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = long_hold ? LONG_HOLD : $urandom_range(0, rx_stall_max);
            long_hold = 1'b0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("sorted_table_binary_search_core verification failed");
        $finish;
    end

    task automatic send_item(logic cmd, logic [INDEX_W-1:0] idx,
                             logic signed [VALUE_W-1:0] val, logic signed [VALUE_W-1:0] key);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_entry_index <= idx;
        s_entry_value <= val;
        s_search_key  <= key;
        do @(posedge aclk); while (!s_ready);
        tracker.note_input(cmd, idx, val, key);
        @(negedge aclk);
    endtask

    task automatic write_entry(logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] val);
        send_item(CMD_WRITE, idx, val, $urandom);
    endtask

    task automatic search_for(logic signed [VALUE_W-1:0] key);
        send_item(CMD_SEARCH, INDEX_W'($urandom), $urandom, key);
    endtask

    // hold off until every search is answered and the block has gone quiet
    task automatic wait_all_answered();
        s_valid <= 1'b0;
        while (tracker.pending_answers.size() != 0) @(posedge aclk);
        @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.entry_count = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_table(int n, fill_mode_t mode);
        longint level, stride;
        stride = (n > 0) ? (64'd4294967295 / n) : 64'd1;
        if (mode == FILL_DENSE) level = longint'(int'($urandom));
        else if ($urandom_range(0, 1)) level = longint'(VALUE_MIN);
        else level = longint'(VALUE_MIN) + longint'($urandom) % (stride + 1);
        for (int i = 0; i < n; i++) begin
            if (mode == FILL_SHUFFLED) begin
                write_entry(INDEX_W'(i), $urandom);
            end else begin
                if (mode == FILL_SPARSE && i == n - 1 && $urandom_range(0, 1))
                    level = longint'(VALUE_MAX);
                write_entry(INDEX_W'(i), level[VALUE_W-1:0]);
                if (mode == FILL_DENSE) level += $urandom_range(0, 2);
                else level += longint'($urandom) % (2 * stride + 1);
                if (level > longint'(VALUE_MAX)) level = longint'(VALUE_MAX);
            end
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_key(int span);
        logic signed [VALUE_W-1:0] k;
        int roll;
        roll = $urandom_range(0, 9);
        if (span == 0 || roll == 8) return $urandom;
        if (roll == 9) return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        k = tracker.table_copy[$urandom_range(0, span - 1)];
        if (roll == 6) k = k + 1;
        if (roll == 7) k = k - 1;
        return k;
    endfunction

    task automatic run_searches(int total, int span);
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 9) == 0) write_entry(INDEX_W'($urandom), $urandom);
            else search_for(pick_key(span));
            random_items++;
        end
    endtask

    initial begin
        int n, span, roll, phase;
        bit table_full;
        fill_mode_t mode;
        phase = 0;
        table_full = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        search_for(0);
        search_for(VALUE_MAX);
        write_entry(0, VALUE_MIN);
        write_entry(INDEX_W'(TABLE_DEPTH_D - 1), VALUE_MAX);
        wait_all_answered();
        write_count(1);
        search_for(VALUE_MIN);
        search_for(5);
        write_entry(1, -5);
        write_entry(2, 0);
        write_entry(3, 7);
        write_entry(4, VALUE_MAX);
        wait_all_answered();
        write_count(5);
        search_for(VALUE_MIN);
        search_for(VALUE_MAX);
        search_for(0);
        search_for(-5);
        search_for(3);
        write_entry(2, 100);
        search_for(100);
        search_for(7);
        wait_all_answered();
        write_count(0);
        search_for(7);

        while (random_items < ITEM_TARGET) begin
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 11;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            wait_all_answered();
            if (phase == FULL_PHASE) begin
                write_count(COUNT_W'(TABLE_DEPTH_D));
                fill_table(TABLE_DEPTH_D, FILL_SPARSE);
                random_items += TABLE_DEPTH_D;
                table_full = 1'b1;
                run_searches(60, TABLE_DEPTH_D);
                wait_all_answered();
                write_count({COUNT_W{1'b1}});
                run_searches(40, TABLE_DEPTH_D);
            end else begin
                roll = $urandom_range(0, 19);
                if (roll == 0) n = 0;
                else if (roll <= 13) n = $urandom_range(1, 40);
                else if (roll <= 17) n = $urandom_range(41, 200);
                else if (roll == 19 && table_full) n = $urandom_range(TABLE_DEPTH_D + 1, 2047);
                else n = $urandom_range(1, 3);
                roll = $urandom_range(0, 9);
                mode = (roll == 0) ? FILL_SHUFFLED : (roll <= 4) ? FILL_DENSE : FILL_SPARSE;
                span = (n > TABLE_DEPTH_D) ? TABLE_DEPTH_D : n;
                write_count(COUNT_W'(n));
                if (n <= TABLE_DEPTH_D) begin
                    fill_table(n, mode);
                    random_items += n;
                end
                if (phase == 1) begin
                    tx_gap_max = 0;
                    long_hold = 1'b1;
                end
                run_searches($urandom_range(8, 40), span);
            end
            phase++;
        end

        wait_all_answered();
        if (tracker.pending_answers.size() != 0) begin
            tracker.errors++;
            $display("%0t: %0d searches never answered", $time, tracker.pending_answers.size());
        end
        if (tracker.errors == 0) begin
            $display("sorted_table_binary_search_core verification clean");
        end else begin
            $display("sorted_table_binary_search_core verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/sts_pkg.sv
hw/rtl/sts_ram.sv
hw/rtl/sorted_table_binary_search_core.sv
hw/rtl/sts_checker.sv
tb/tb.sv
